>>> sv/tmc_pkg.sv
// Shared definitions for the two-means clustering block.
// Holds parameter defaults, configuration register indexes and the sequencer state type.
// No dependencies.
package tmc_pkg;

    localparam int DEF_MAX_POINTS   = 64;
    localparam int DEF_MAX_FEATURES = 8;
    localparam int DEF_VALUE_BITS   = 16;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SEED    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SEED   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_COUNT    = 2'd3;

    localparam logic [3:0] RST_FEATURE_COUNT = 4'd2;
    localparam logic [5:0] RST_FIRST_SEED    = 6'd0;
    localparam logic [5:0] RST_SECOND_SEED   = 6'd1;
    localparam logic [4:0] RST_PASS_COUNT    = 5'd10;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SEED,
        ST_SEED_RD,
        ST_SEED_WR0,
        ST_SEED_WR1,
        ST_PASS,
        ST_POINT,
        ST_D_RD,
        ST_D_DIFF,
        ST_D_SQ,
        ST_D_ACC0,
        ST_D_ACC1,
        ST_LABEL,
        ST_A_RD,
        ST_A_ADD,
        ST_DIV_SEL,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

endpackage

>>> sv/tmc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the point store, the point length store and the label store.
// No dependencies.
module tmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/tmc_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
// The quotient is truncated toward zero. No package dependencies.
module tmc_div #(
    parameter int NW  = 31,
    parameter int DVW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [DVW-1:0]       divisor,
    output logic                 done,
    output logic signed [NW-1:0] quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic           neg_reg;
    logic [DVW-1:0] den_reg;
    logic [DVW-1:0] rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DVW:0]   trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NW-1];
            quo_reg <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DVW'(trial - {1'b0, den_reg}) : DVW'(trial);
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

>>> sv/two_means_clustering.sv
// Two-means clustering under one sequencer with a shared squarer and a shared divider.
// Values load one per cycle; the input is not ready from the closing value to the last label.
// Seeding copies both seed points into the centroids; each pass then measures the distance of
// every point to both centroids. Every pass but the last also sums each cluster's points and runs
// up to 2*F divisions for the new means. Each label is read from its store, then offered.
// Reset loads register defaults and clears counters and sums; stores are undefined until written.
module two_means_clustering #(
    parameter int MAX_POINTS   = tmc_pkg::DEF_MAX_POINTS,
    parameter int MAX_FEATURES = tmc_pkg::DEF_MAX_FEATURES,
    parameter int VALUE_BITS   = tmc_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS    = tmc_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [VALUE_BITS-1:0]       feature_value,
    input  logic                               last_of_set,
    output logic                               label_valid,
    input  logic                               label_ready,
    output logic [1:0]                         cluster_label,
    output logic                               last_label,
    input  logic                               cfg_write,
    input  logic [tmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tmc_pkg::*;

    localparam int PIW = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FCW = $clog2(MAX_FEATURES + 1);
    localparam int AW  = $clog2(MAX_POINTS * MAX_FEATURES);
    localparam int CW  = VALUE_BITS + FRAC_BITS;
    localparam int DW  = CW + 1;
    localparam int QW  = 2 * DW - 1;
    localparam int DSW = QW + FCW;
    localparam int SW  = VALUE_BITS + PIW + 1;
    localparam int NW  = SW + FRAC_BITS;

    state_t state_reg, state_next;

    logic [3:0] fc_cfg_reg;
    logic [5:0] seed0_cfg_reg;
    logic [5:0] seed1_cfg_reg;
    logic [4:0] pass_cfg_reg;

    logic [FCW-1:0] fc_eff;
    logic [4:0]     passes_eff;
    logic           last_pass;

    logic [PCW-1:0] pts_reg;
    logic [FCW-1:0] pos_reg;
    logic [PCW-1:0] n_reg;
    logic [PCW-1:0] i_reg;
    logic [FCW-1:0] j_reg;
    logic [4:0]     pass_reg;
    logic           cl_reg;
    logic           lbl_reg;
    logic [PIW-1:0] s0_reg;
    logic [PIW-1:0] s1_reg;
    logic [PCW-1:0] cnt_reg [2];
    logic signed [SW-1:0] sum_reg [2][MAX_FEATURES];

    logic signed [CW-1:0] cent_reg [2][MAX_FEATURES];
    logic signed [VALUE_BITS-1:0] x_reg;
    logic signed [DW-1:0]   diff_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic [DSW-1:0]         d0_reg;
    logic [DSW-1:0]         d1_reg;

    // Load bookkeeping for the transaction on the input channel.
    logic           item_take;
    logic           ld_pre_close;
    logic [PCW-1:0] ld_pt;
    logic [FCW-1:0] ld_pos;
    logic [FCW-1:0] ld_pos_inc;
    logic           ld_room;
    logic           ld_close;
    logic [PCW-1:0] ld_pts_next;
    logic [FCW-1:0] ld_pos_next;

    logic [7:0] n_ext;
    logic [7:0] sd0_sat;
    logic [7:0] sd1_sat;
    logic [7:0] sd1_fin;

    logic [PIW-1:0]        rd_pt;
    logic [AW-1:0]         pt_rd_addr;
    logic [AW-1:0]         pt_wr_addr;
    logic                  pt_wr_en;
    logic [VALUE_BITS-1:0] pt_rd_data;
    logic [FCW-1:0]        len_rd_data;
    logic                  lab_wr_en;
    logic                  lab_rd_data;
    logic                  d_gt;

    logic signed [VALUE_BITS-1:0] x_mask;
    logic signed [DW-1:0]         xs_data;
    logic signed [DW-1:0]         xs_held;

    logic [FW-1:0] jx;
    logic          div_go;
    logic          div_start;
    logic          div_done;
    logic signed [NW-1:0] div_quot;
    logic signed [NW-1:0] div_dividend;

    always_comb
    begin
        if (fc_cfg_reg == 4'd0)
        begin
            fc_eff = FCW'(1);
        end
        else if ({1'b0, fc_cfg_reg} > 5'(MAX_FEATURES))
        begin
            fc_eff = FCW'(MAX_FEATURES);
        end
        else
        begin
            fc_eff = FCW'(fc_cfg_reg);
        end
        passes_eff = (pass_cfg_reg == 5'd0) ? 5'd1 : pass_cfg_reg;
        last_pass  = (5'(pass_reg + 5'd1) == passes_eff);
    end

    assign item_take    = item_valid && item_ready;
    assign ld_pre_close = pos_reg >= fc_eff;
    assign ld_pt        = ld_pre_close ? PCW'(pts_reg + PCW'(1)) : pts_reg;
    assign ld_pos       = ld_pre_close ? '0 : pos_reg;
    assign ld_pos_inc   = FCW'(ld_pos + FCW'(1));
    assign ld_room      = (pts_reg < PCW'(MAX_POINTS)) && (ld_pt < PCW'(MAX_POINTS));
    assign ld_close     = (ld_pos_inc >= fc_eff) || last_of_set;

    always_comb
    begin
        if (!(pts_reg < PCW'(MAX_POINTS)))
        begin
            ld_pts_next = pts_reg;
            ld_pos_next = pos_reg;
        end
        else if (!ld_room)
        begin
            ld_pts_next = ld_pt;
            ld_pos_next = ld_pos;
        end
        else if (ld_close)
        begin
            ld_pts_next = PCW'(ld_pt + PCW'(1));
            ld_pos_next = '0;
        end
        else
        begin
            ld_pts_next = ld_pt;
            ld_pos_next = ld_pos_inc;
        end
    end

    // Seed indexes saturate to the last point; equal seeds move the second one.
    assign n_ext   = 8'(n_reg);
    assign sd0_sat = ({2'b00, seed0_cfg_reg} >= n_ext) ? 8'(n_ext - 8'd1) : {2'b00, seed0_cfg_reg};
    assign sd1_sat = ({2'b00, seed1_cfg_reg} >= n_ext) ? 8'(n_ext - 8'd1) : {2'b00, seed1_cfg_reg};
    assign sd1_fin = (sd0_sat == sd1_sat) ? 8'(n_ext - 8'd1 - sd0_sat) : sd1_sat;

    assign jx      = j_reg[FW-1:0];
    assign x_mask  = (j_reg < len_rd_data) ? $signed(pt_rd_data) : '0;
    assign xs_data = DW'(x_mask) <<< FRAC_BITS;
    assign xs_held = DW'(x_reg) <<< FRAC_BITS;
    assign d_gt    = d0_reg > d1_reg;
    assign div_go  = (j_reg != fc_eff) && (cnt_reg[cl_reg] != '0);
    assign div_dividend = NW'(sum_reg[cl_reg][jx]) <<< FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_take && last_of_set)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:     state_next = ST_SEED_RD;
            ST_SEED_RD:  state_next = ST_SEED_WR0;
            ST_SEED_WR0: state_next = ST_SEED_WR1;
            ST_SEED_WR1:
            begin
                state_next = (FCW'(j_reg + FCW'(1)) == fc_eff) ? ST_PASS : ST_SEED_RD;
            end
            ST_PASS:     state_next = ST_POINT;
            ST_POINT:    state_next = ST_D_RD;
            ST_D_RD:     state_next = ST_D_DIFF;
            ST_D_DIFF:   state_next = ST_D_SQ;
            ST_D_SQ:     state_next = ST_D_ACC0;
            ST_D_ACC0:   state_next = ST_D_ACC1;
            ST_D_ACC1:
            begin
                state_next = (FCW'(j_reg + FCW'(1)) == fc_eff) ? ST_LABEL : ST_D_RD;
            end
            ST_LABEL:
            begin
                if (!last_pass)
                begin
                    state_next = ST_A_RD;
                end
                else if (PCW'(i_reg + PCW'(1)) == n_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_POINT;
                end
            end
            ST_A_RD:     state_next = ST_A_ADD;
            ST_A_ADD:
            begin
                if (FCW'(j_reg + FCW'(1)) == fc_eff)
                begin
                    state_next = (PCW'(i_reg + PCW'(1)) == n_reg) ? ST_DIV_SEL : ST_POINT;
                end
                else
                begin
                    state_next = ST_A_RD;
                end
            end
            ST_DIV_SEL:
            begin
                if (div_go)
                begin
                    state_next = ST_DIV_WAIT;
                end
                else if (cl_reg)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_SEL;
                end
            end
            ST_EMIT_RD:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (label_ready)
                begin
                    state_next = (PCW'(i_reg + PCW'(1)) == n_reg) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        item_ready  = (state_reg == ST_LOAD);
        label_valid = (state_reg == ST_EMIT);
        pt_wr_en    = item_take && ld_room;
        lab_wr_en   = (state_reg == ST_LABEL);
        div_start   = (state_reg == ST_DIV_SEL) && div_go;
        unique case (state_reg)
            ST_SEED_RD:  rd_pt = s0_reg;
            ST_SEED_WR0: rd_pt = s1_reg;
            default:     rd_pt = i_reg[PIW-1:0];
        endcase
    end

    assign pt_rd_addr = AW'(rd_pt) * AW'(MAX_FEATURES) + AW'(j_reg);
    assign pt_wr_addr = AW'(ld_pt[PIW-1:0]) * AW'(MAX_FEATURES) + AW'(ld_pos);

    assign cluster_label = lab_rd_data ? 2'd2 : 2'd1;
    assign last_label    = (PCW'(i_reg + PCW'(1)) == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fc_cfg_reg    <= RST_FEATURE_COUNT;
            seed0_cfg_reg <= RST_FIRST_SEED;
            seed1_cfg_reg <= RST_SECOND_SEED;
            pass_cfg_reg  <= RST_PASS_COUNT;
            pts_reg       <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pass_reg      <= '0;
            cl_reg        <= 1'b0;
            lbl_reg       <= 1'b0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            for (int c = 0; c < 2; c++)
            begin
                for (int f = 0; f < MAX_FEATURES; f++)
                begin
                    sum_reg[c][f] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FEATURE_COUNT: fc_cfg_reg    <= cfg_data[3:0];
                    CFG_FIRST_SEED:    seed0_cfg_reg <= cfg_data;
                    CFG_SECOND_SEED:   seed1_cfg_reg <= cfg_data;
                    CFG_PASS_COUNT:    pass_cfg_reg  <= cfg_data[4:0];
                    default:           ;
                endcase
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (item_take)
                    begin
                        if (last_of_set)
                        begin
                            n_reg   <= ld_pts_next;
                            pts_reg <= '0;
                            pos_reg <= '0;
                        end
                        else
                        begin
                            pts_reg <= ld_pts_next;
                            pos_reg <= ld_pos_next;
                        end
                    end
                end
                ST_SEED:
                begin
                    s0_reg   <= PIW'(sd0_sat);
                    s1_reg   <= PIW'(sd1_fin);
                    j_reg    <= '0;
                    pass_reg <= '0;
                end
                ST_SEED_WR1:
                begin
                    j_reg <= FCW'(j_reg + FCW'(1));
                end
                ST_PASS:
                begin
                    i_reg      <= '0;
                    cnt_reg[0] <= '0;
                    cnt_reg[1] <= '0;
                    for (int c = 0; c < 2; c++)
                    begin
                        for (int f = 0; f < MAX_FEATURES; f++)
                        begin
                            sum_reg[c][f] <= '0;
                        end
                    end
                end
                ST_POINT:
                begin
                    j_reg <= '0;
                end
                ST_D_ACC1:
                begin
                    j_reg <= FCW'(j_reg + FCW'(1));
                end
                ST_LABEL:
                begin
                    lbl_reg <= d_gt;
                    if (last_pass)
                    begin
                        i_reg <= (PCW'(i_reg + PCW'(1)) == n_reg) ? '0 : PCW'(i_reg + PCW'(1));
                    end
                    else
                    begin
                        cnt_reg[d_gt] <= PCW'(cnt_reg[d_gt] + PCW'(1));
                        j_reg         <= '0;
                    end
                end
                ST_A_ADD:
                begin
                    sum_reg[lbl_reg][jx] <= SW'(sum_reg[lbl_reg][jx] + SW'(x_mask));
                    if (FCW'(j_reg + FCW'(1)) == fc_eff)
                    begin
                        if (PCW'(i_reg + PCW'(1)) == n_reg)
                        begin
                            cl_reg <= 1'b0;
                            j_reg  <= '0;
                        end
                        else
                        begin
                            i_reg <= PCW'(i_reg + PCW'(1));
                        end
                    end
                    else
                    begin
                        j_reg <= FCW'(j_reg + FCW'(1));
                    end
                end
                ST_DIV_SEL:
                begin
                    if (!div_go)
                    begin
                        if (cl_reg)
                        begin
                            pass_reg <= 5'(pass_reg + 5'd1);
                        end
                        else
                        begin
                            cl_reg <= 1'b1;
                            j_reg  <= '0;
                        end
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        j_reg <= FCW'(j_reg + FCW'(1));
                    end
                end
                ST_EMIT:
                begin
                    if (label_ready)
                    begin
                        i_reg <= PCW'(i_reg + PCW'(1));
                    end
                end
                default: ;
            endcase
        end
    end

    // Centroids and the squaring pipeline: one multiplier serves both clusters in turn.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_SEED_WR0:
            begin
                cent_reg[0][jx] <= CW'(xs_data);
            end
            ST_SEED_WR1:
            begin
                cent_reg[1][jx] <= CW'(xs_data);
            end
            ST_POINT:
            begin
                d0_reg <= '0;
                d1_reg <= '0;
            end
            ST_D_DIFF:
            begin
                x_reg    <= x_mask;
                diff_reg <= DW'(xs_data - DW'(cent_reg[0][jx]));
            end
            ST_D_SQ:
            begin
                prod_reg <= diff_reg * diff_reg;
                diff_reg <= DW'(xs_held - DW'(cent_reg[1][jx]));
            end
            ST_D_ACC0:
            begin
                d0_reg   <= DSW'(d0_reg + DSW'(prod_reg[QW-1:0]));
                prod_reg <= diff_reg * diff_reg;
            end
            ST_D_ACC1:
            begin
                d1_reg <= DSW'(d1_reg + DSW'(prod_reg[QW-1:0]));
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    cent_reg[cl_reg][jx] <= CW'(div_quot);
                end
            end
            default: ;
        endcase
    end

    tmc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_POINTS * MAX_FEATURES)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (feature_value),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    // Number of values each point received; slots beyond it read as zero.
    tmc_ram #(
        .WIDTH (FCW),
        .DEPTH (MAX_POINTS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (ld_pt[PIW-1:0]),
        .wr_data (ld_pos_inc),
        .rd_addr (rd_pt),
        .rd_data (len_rd_data)
    );

    tmc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_POINTS)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (lab_wr_en),
        .wr_addr (i_reg[PIW-1:0]),
        .wr_data (d_gt),
        .rd_addr (i_reg[PIW-1:0]),
        .rd_data (lab_rd_data)
    );

    tmc_div #(
        .NW  (NW),
        .DVW (PCW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg[cl_reg]),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

>>> tb/sv/two_means_clustering_checker.sv
// Checker for the two-means clustering block: snoops configuration writes and loaded values,
// predicts the label sequence of every closed set and compares each label transaction.
// Depends on tmc_pkg for register indexes and reset values.
module two_means_clustering_checker #(
    parameter int MAX_POINTS   = tmc_pkg::DEF_MAX_POINTS,
    parameter int MAX_FEATURES = tmc_pkg::DEF_MAX_FEATURES,
    parameter int FRAC_BITS    = tmc_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_ready,
    input  logic signed [15:0]                feature_value,
    input  logic                              last_of_set,
    input  logic                              label_valid,
    input  logic                              label_ready,
    input  logic [1:0]                        cluster_label,
    input  logic                              last_label,
    input  logic                              cfg_write,
    input  logic [tmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                labels_checked
);

    import tmc_pkg::*;

    localparam logic [1:0] LABEL_ONE = 2'd1;
    localparam logic [1:0] LABEL_TWO = 2'd2;

    typedef struct packed {
        logic [1:0] label;
        logic       last;
    } label_t;

    label_t     expected_labels[$];
    logic [3:0] feature_cfg;
    logic [5:0] seed_one_cfg;
    logic [5:0] seed_two_cfg;
    logic [4:0] pass_cfg;
    longint     points[MAX_POINTS][MAX_FEATURES];
    int         loaded;
    int         position;

    function automatic int active_features();
        if (feature_cfg == 0)
            return 1;
        if (feature_cfg > MAX_FEATURES)
            return MAX_FEATURES;
        return int'(feature_cfg);
    endfunction

    task automatic close_point();
        for (int j = position; j < MAX_FEATURES; j++)
            points[loaded][j] = 0;
        loaded++;
        position = 0;
    endtask

    // Seeds both centroids, runs the assignment passes with mean updates in between,
    // and queues one label per point in load order.
    task automatic cluster_set(input int n, input int fc);
        int     s0;
        int     s1;
        int     passes;
        int     counts[2];
        bit     member_two[MAX_POINTS];
        longint centroid[2][MAX_FEATURES];
        longint sums[2][MAX_FEATURES];
        longint scale;
        longint x;
        longint d1;
        longint d2;
        label_t lbl;
        scale  = longint'(1) << FRAC_BITS;
        s0     = int'(seed_one_cfg);
        s1     = int'(seed_two_cfg);
        passes = (pass_cfg == 0) ? 1 : int'(pass_cfg);
        if (s0 >= n) s0 = n - 1;
        if (s1 >= n) s1 = n - 1;
        if (s0 == s1) s1 = n - 1 - s0;
        for (int j = 0; j < fc; j++)
        begin
            centroid[0][j] = points[s0][j] * scale;
            centroid[1][j] = points[s1][j] * scale;
        end
        for (int p = 0; p < passes; p++)
        begin
            for (int i = 0; i < n; i++)
            begin
                d1 = 0;
                d2 = 0;
                for (int j = 0; j < fc; j++)
                begin
                    x  = points[i][j] * scale;
                    d1 += (x - centroid[0][j]) * (x - centroid[0][j]);
                    d2 += (x - centroid[1][j]) * (x - centroid[1][j]);
                end
                member_two[i] = (d1 > d2);
            end
            if (p + 1 == passes)
                break;
            counts = '{0, 0};
            for (int c = 0; c < 2; c++)
                for (int j = 0; j < MAX_FEATURES; j++)
                    sums[c][j] = 0;
            for (int i = 0; i < n; i++)
            begin
                counts[member_two[i]]++;
                for (int j = 0; j < fc; j++)
                    sums[member_two[i]][j] += points[i][j];
            end
            // An empty cluster keeps the centroid it had.
            for (int c = 0; c < 2; c++)
                if (counts[c] != 0)
                    for (int j = 0; j < fc; j++)
                        centroid[c][j] = (sums[c][j] * scale) / longint'(counts[c]);
        end
        for (int i = 0; i < n; i++)
        begin
            lbl.label = member_two[i] ? LABEL_TWO : LABEL_ONE;
            lbl.last  = (i == n - 1);
            expected_labels.push_back(lbl);
        end
    endtask

    task automatic load_value(input longint v, input bit closes_set);
        int fc;
        fc = active_features();
        if (loaded < MAX_POINTS)
        begin
            if (position >= fc)
                close_point();
            if (loaded < MAX_POINTS)
            begin
                points[loaded][position] = v;
                position++;
                if (position >= fc || closes_set)
                    close_point();
            end
        end
        if (closes_set && loaded != 0)
        begin
            cluster_set(loaded, fc);
            loaded   = 0;
            position = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        label_t want;
        if (!rst_n)
        begin
            feature_cfg    = RST_FEATURE_COUNT;
            seed_one_cfg   = RST_FIRST_SEED;
            seed_two_cfg   = RST_SECOND_SEED;
            pass_cfg       = RST_PASS_COUNT;
            loaded         = 0;
            position       = 0;
            fail_count     = 0;
            labels_checked = 0;
            expected_labels.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FEATURE_COUNT: feature_cfg  = cfg_data[3:0];
                    CFG_FIRST_SEED:    seed_one_cfg = cfg_data[5:0];
                    CFG_SECOND_SEED:   seed_two_cfg = cfg_data[5:0];
                    CFG_PASS_COUNT:    pass_cfg     = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (label_valid && label_ready)
            begin
                labels_checked++;
                if (expected_labels.size() == 0)
                begin
                    $error("label transaction with none expected: cluster_label %0d last_label %0d",
                           cluster_label, last_label);
                    fail_count++;
                end
                else
                begin
                    want = expected_labels.pop_front();
                    if (cluster_label !== want.label)
                    begin
                        $error("cluster_label expected %0d actual %0d", want.label, cluster_label);
                        fail_count++;
                    end
                    if (last_label !== want.last)
                    begin
                        $error("last_label expected %0d actual %0d", want.last, last_label);
                        fail_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                load_value(longint'(feature_value), last_of_set);
        end
        pending = expected_labels.size();
    end

endmodule

>>> tb/sv/two_means_clustering_tb.sv
// Testbench top for the two-means clustering block: reset, configuration writes,
// point-set stimulus with sender and receiver idling, and the final verdict.
// Depends on tmc_pkg, two_means_clustering and two_means_clustering_checker.
module two_means_clustering_tb;
    import tmc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    logic signed [15:0]     feature_value = '0;
    logic                   last_of_set = 1'b0;
    logic                   label_valid;
    logic                   label_ready = 1'b0;
    logic [1:0]             cluster_label;
    logic                   last_label;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int labels_checked;
    int send_idle = 34;
    int recv_idle = 74;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int items_sent = 0;
    int sets_sent = 0;
    int cycles = 0;

    two_means_clustering dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .feature_value(feature_value), .last_of_set(last_of_set),
        .label_valid(label_valid), .label_ready(label_ready),
        .cluster_label(cluster_label), .last_label(last_label),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    two_means_clustering_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .feature_value(feature_value), .last_of_set(last_of_set),
        .label_valid(label_valid), .label_ready(label_ready),
        .cluster_label(cluster_label), .last_label(last_label),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .labels_checked(labels_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL two_means_clustering");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
    // The hold-off outlasts loading and clustering of a full store, so labels back up.
    always @(negedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left  = 3000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            label_ready <= 1'b0;
        end
        else
            label_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_value(input logic signed [15:0] v, input bit closes_set);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid    <= 1'b1;
        feature_value <= v;
        last_of_set   <= closes_set;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic configure(input int fc, input int s0, input int s1, input int passes);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_FEATURE_COUNT;
        cfg_data  <= CFG_DATA_W'(fc);
        @(negedge clk);
        cfg_index <= CFG_FIRST_SEED;
        cfg_data  <= CFG_DATA_W'(s0);
        @(negedge clk);
        cfg_index <= CFG_SECOND_SEED;
        cfg_data  <= CFG_DATA_W'(s1);
        @(negedge clk);
        cfg_index <= CFG_PASS_COUNT;
        cfg_data  <= CFG_DATA_W'(passes);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Points scatter around two random centers, with some full-range noise values.
    // A short final point drops its trailing values.
    task automatic send_set(input int n, input int fc, input bit short_tail);
        int          ca;
        int          cb;
        int          spread;
        int          center;
        int          count;
        int          v;
        ca     = $urandom_range(40000) - 20000;
        cb     = $urandom_range(40000) - 20000;
        spread = $urandom_range(3000);
        for (int i = 0; i < n; i++)
        begin
            center = $urandom_range(1) ? ca : cb;
            count  = (short_tail && i == n - 1 && fc > 1) ? $urandom_range(fc - 1, 1) : fc;
            for (int j = 0; j < count; j++)
            begin
                if ($urandom_range(15) == 0)
                    v = int'($signed(16'($urandom)));
                else
                    v = center + $urandom_range(2 * spread) - spread;
                send_value(16'(v), (i == n - 1) && (j == count - 1));
            end
        end
        sets_sent++;
    endtask

    initial
    begin
        int n;
        int fc;
        int active;
        int passes;
        bit full_done;
        full_done = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, extreme values, equidistant point.
        send_value(16'sh8000, 0);
        send_value(16'sh7fff, 0);
        send_value(16'sh7fff, 0);
        send_value(16'sh8000, 0);
        send_value(16'sh0000, 0);
        send_value(16'sh0000, 1);
        // Zero feature count and zero passes, equal seeds past the end, one-point set.
        configure(0, 5, 5, 0);
        send_value(16'sh1234, 1);
        // Oversized feature count and the largest pass count, short final point.
        configure(9, 63, 0, 31);
        for (int j = 0; j < 8; j++)
            send_value(16'(j * 4111 - 15000), 0);
        send_value(16'sh5555, 0);
        send_value(16'shaaaa, 1);
        // Feature count grows while a set is loading.
        configure(2, 1, 0, 3);
        send_value(16'sh0100, 0);
        configure(3, 1, 0, 3);
        send_value(16'sh0200, 0);
        send_value(16'sh0300, 0);
        send_value(-16'sh0100, 0);
        send_value(16'sh0007, 1);
        sets_sent += 4;

        while (items_sent < 310)
        begin
            if (items_sent < 110)
            begin
                send_idle = 34;
                recv_idle = 74;
            end
            else if (items_sent < 210)
            begin
                send_idle = 74;
                recv_idle = 34;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (items_sent >= 210 && !full_done)
            begin
                // Overfill the store while the receiver holds off, then keep offering
                // the next set so that input stalls behind the label backlog.
                full_done = 1;
                configure(1, 0, 63, 2);
                holds_asked++;
                for (int i = 0; i < 70; i++)
                    send_value(16'($urandom), i == 69);
                sets_sent++;
                send_set(5, 1, 0);
                continue;
            end
            n  = $urandom_range(10, 2);
            fc = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4, 1);
            active = (fc == 0) ? 1 : (fc > 8) ? 8 : fc;
            passes = ($urandom_range(11) == 0) ? $urandom_range(31, 16) : $urandom_range(6);
            if (passes > 15)
                n = $urandom_range(4, 2);
            configure(fc,
                      ($urandom_range(7) == 0) ? 63 : $urandom_range(n + 1),
                      ($urandom_range(7) == 0) ? 63 : $urandom_range(n + 1),
                      passes);
            send_set(n, active, $urandom_range(5) == 0);
        end

        wait_idle();
        repeat (60) @(negedge clk);
        $display("Loaded %0d values in %0d point sets and checked %0d labels,",
                 items_sent, sets_sent, labels_checked);
        $display("including a store overflow and label back-pressure; failures: %0d.", fail_count);
        if (fail_count == 0)
            $display("PASS two_means_clustering");
        else
            $display("FAIL two_means_clustering");
        $finish;
    end

endmodule
